### sv/huffman_code_builder_macros.svh
// assertion macros for the huffman code builder
`ifndef HUFFMAN_CODE_BUILDER_MACROS_SVH
`define HUFFMAN_CODE_BUILDER_MACROS_SVH

// condition holds in the same cycle
`define HCB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hcb check failed");

// condition holds in the next cycle
`define HCB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hcb check failed");

`endif

### sv/hcb_pkg.sv
`default_nettype none
package hcb_pkg;

  localparam int Alpha      = 26;
  localparam int CountW     = 16;
  localparam int Nodes      = 2 * Alpha - 1;
  localparam int StackDepth = Alpha + 1;
  localparam int HeapAw     = $clog2(Alpha);
  localparam int NodeW      = $clog2(Nodes);
  localparam int StackAw    = $clog2(StackDepth);
  localparam int SymW       = 5;
  localparam int LenW       = 5;
  localparam int CodeW      = 25;
  localparam logic [7:0] FirstLetter = 8'd97;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_req_t;

  typedef struct packed {
    logic [SymW-1:0]   symbol;
    logic [LenW-1:0]   code_length;
    logic [CodeW-1:0]  code_bits;
    logic [CountW-1:0] weight;
    logic              empty_message;
    logic              last_code;
  } out_req_t;

  typedef struct packed {
    logic [CountW-1:0] w;
    logic [NodeW-1:0]  n;
  } heap_ent_t;

  typedef struct packed {
    logic [CountW-1:0] w;
    logic [NodeW-1:0]  l;
    logic [NodeW-1:0]  r;
    logic [SymW-1:0]   sym;
  } node_ent_t;

  typedef struct packed {
    logic [NodeW-1:0] n;
    logic [CodeW-1:0] code;
    logic [LenW-1:0]  len;
  } stack_ent_t;

  typedef logic [4:0] op_t;

  localparam op_t OpIdle   = 5'd0;
  localparam op_t OpCount  = 5'd1;
  localparam op_t OpScan   = 5'd2;
  localparam op_t OpEmpty  = 5'd3;
  localparam op_t OpRbInit = 5'd4;
  localparam op_t OpRbNext = 5'd5;
  localparam op_t OpSr0    = 5'd6;
  localparam op_t OpSr1    = 5'd7;
  localparam op_t OpScmp   = 5'd8;
  localparam op_t OpSwr    = 5'd9;
  localparam op_t OpP0     = 5'd10;
  localparam op_t OpP1     = 5'd11;
  localparam op_t OpP2     = 5'd12;
  localparam op_t OpPush   = 5'd13;
  localparam op_t OpWr0    = 5'd14;
  localparam op_t OpWr1    = 5'd15;
  localparam op_t OpW0     = 5'd16;
  localparam op_t OpW1     = 5'd17;
  localparam op_t OpEmit   = 5'd18;
  localparam op_t OpW2     = 5'd19;
  localparam op_t OpW3     = 5'd20;

  typedef struct packed {
    op_t  op;
    logic acc;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic leaves_zero;
    logic ri_zero;
    logic sift_stop;
    logic size_one;
    logic sp_zero;
    logic is_leaf;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

### sv/hcb_ctrl.sv
`default_nettype none
module hcb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire hcb_pkg::in_req_t in_data,
  output logic               in_stall,
  input  wire hcb_pkg::stat_t st,
  output hcb_pkg::cmd_t      cmd
);

  localparam logic [4:0] S_COUNT = 5'd0;
  localparam logic [4:0] S_SCAN  = 5'd1;
  localparam logic [4:0] S_CHK   = 5'd2;
  localparam logic [4:0] S_EMPTY = 5'd3;
  localparam logic [4:0] S_RBI   = 5'd4;
  localparam logic [4:0] S_RBN   = 5'd5;
  localparam logic [4:0] S_SR0   = 5'd6;
  localparam logic [4:0] S_SR1   = 5'd7;
  localparam logic [4:0] S_SCMP  = 5'd8;
  localparam logic [4:0] S_SWR   = 5'd9;
  localparam logic [4:0] S_P0    = 5'd10;
  localparam logic [4:0] S_P1    = 5'd11;
  localparam logic [4:0] S_P2    = 5'd12;
  localparam logic [4:0] S_PUSH  = 5'd13;
  localparam logic [4:0] S_WR0   = 5'd14;
  localparam logic [4:0] S_WR1   = 5'd15;
  localparam logic [4:0] S_W0    = 5'd16;
  localparam logic [4:0] S_W1    = 5'd17;
  localparam logic [4:0] S_W2    = 5'd18;
  localparam logic [4:0] S_W3    = 5'd19;

  localparam logic [1:0] R_INIT = 2'd0;
  localparam logic [1:0] R_POP1 = 2'd1;
  localparam logic [1:0] R_POP2 = 2'd2;
  localparam logic [1:0] R_PUSH = 2'd3;

  logic [4:0] state_r, state_nxt;
  logic [1:0] ret_r, ret_nxt;

  assign in_stall = (state_r != S_COUNT);

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    cmd.op    = hcb_pkg::OpIdle;
    cmd.acc   = 1'b0;
    case (state_r)
      S_COUNT: begin
        cmd.op  = hcb_pkg::OpCount;
        cmd.acc = in_valid;
        if (in_valid && in_data.last_char) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.op = hcb_pkg::OpScan;
        if (st.scan_last) state_nxt = S_CHK;
      end
      S_CHK: begin
        ret_nxt   = R_INIT;
        state_nxt = st.leaves_zero ? S_EMPTY : S_RBI;
      end
      S_EMPTY: begin
        if (st.out_free) begin
          cmd.op    = hcb_pkg::OpEmpty;
          state_nxt = S_COUNT;
        end
      end
      S_RBI: begin
        cmd.op    = hcb_pkg::OpRbInit;
        state_nxt = S_RBN;
      end
      S_RBN: begin
        if (!st.ri_zero) begin
          cmd.op    = hcb_pkg::OpRbNext;
          state_nxt = S_SR0;
        end else begin
          case (ret_r)
            R_POP1: begin
              ret_nxt   = R_POP2;
              state_nxt = S_P0;
            end
            R_POP2: state_nxt = S_PUSH;
            default: begin
              if (st.size_one) begin
                state_nxt = S_WR0;
              end else begin
                ret_nxt   = R_POP1;
                state_nxt = S_P0;
              end
            end
          endcase
        end
      end
      S_SR0: begin
        cmd.op    = hcb_pkg::OpSr0;
        state_nxt = S_SR1;
      end
      S_SR1: begin
        cmd.op    = hcb_pkg::OpSr1;
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        cmd.op    = hcb_pkg::OpScmp;
        state_nxt = st.sift_stop ? S_RBN : S_SWR;
      end
      S_SWR: begin
        cmd.op    = hcb_pkg::OpSwr;
        state_nxt = S_SR0;
      end
      S_P0: begin
        cmd.op    = hcb_pkg::OpP0;
        state_nxt = S_P1;
      end
      S_P1: begin
        cmd.op    = hcb_pkg::OpP1;
        state_nxt = S_P2;
      end
      S_P2: begin
        cmd.op    = hcb_pkg::OpP2;
        state_nxt = S_RBI;
      end
      S_PUSH: begin
        cmd.op    = hcb_pkg::OpPush;
        ret_nxt   = R_PUSH;
        state_nxt = S_RBI;
      end
      S_WR0: begin
        cmd.op    = hcb_pkg::OpWr0;
        state_nxt = S_WR1;
      end
      S_WR1: begin
        cmd.op    = hcb_pkg::OpWr1;
        state_nxt = S_W0;
      end
      S_W0: begin
        if (st.sp_zero) begin
          state_nxt = S_COUNT;
        end else begin
          cmd.op    = hcb_pkg::OpW0;
          state_nxt = S_W1;
        end
      end
      S_W1: begin
        cmd.op    = hcb_pkg::OpW1;
        state_nxt = S_W2;
      end
      S_W2: begin
        if (st.is_leaf) begin
          if (st.out_free) begin
            cmd.op    = hcb_pkg::OpEmit;
            state_nxt = S_W0;
          end
        end else begin
          cmd.op    = hcb_pkg::OpW2;
          state_nxt = S_W3;
        end
      end
      S_W3: begin
        cmd.op    = hcb_pkg::OpW3;
        state_nxt = S_W0;
      end
      default: state_nxt = S_COUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_COUNT;
      ret_r   <= R_INIT;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/hcb_dp.sv
`default_nettype none
`include "huffman_code_builder_macros.svh"
module hcb_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire hcb_pkg::cmd_t     cmd,
  input  wire hcb_pkg::in_req_t  in_data,
  output hcb_pkg::stat_t         st,
  output logic                   out_valid,
  output hcb_pkg::out_req_t      out_data,
  input  wire logic              out_stall
);

  localparam int HA = hcb_pkg::HeapAw;
  localparam int NW = hcb_pkg::NodeW;
  localparam int SA = hcb_pkg::StackAw;
  localparam int CW = hcb_pkg::CountW;
  localparam logic [CW-1:0] CntMax = {CW{1'b1}};
  localparam logic [HA-1:0] LastIdx = HA'(hcb_pkg::Alpha - 1);

  logic [CW-1:0] cnt_r [hcb_pkg::Alpha];

  hcb_pkg::heap_ent_t  hp [hcb_pkg::Alpha];
  hcb_pkg::node_ent_t  nd [hcb_pkg::Nodes];
  hcb_pkg::stack_ent_t sk [hcb_pkg::StackDepth];

  logic [HA-1:0] scan_r, scan_nxt;
  logic [HA:0]   leaves_r, leaves_nxt;
  logic [HA:0]   size_r, size_nxt;
  logic [HA-1:0] ri_r, ri_nxt;
  logic [HA-1:0] at_r, at_nxt;
  logic [HA-1:0] m_r, m_nxt;
  logic [NW-1:0] next_r, next_nxt;
  logic [SA-1:0] sp_r, sp_nxt;
  hcb_pkg::heap_ent_t  cur_r, cur_nxt, top_r, top_nxt, a_r, a_nxt, b_r, b_nxt;
  hcb_pkg::stack_ent_t e_r, e_nxt;
  logic              ov_r, ov_nxt;
  hcb_pkg::out_req_t od_r, od_nxt;

  logic               hp_rea, hp_reb, hp_we;
  logic [HA-1:0]      hp_aa, hp_ab, hp_wa;
  hcb_pkg::heap_ent_t hp_wd, hpa_q, hpb_q;
  logic               nd_re, nd_we;
  logic [NW-1:0]      nd_ra, nd_wa;
  hcb_pkg::node_ent_t nd_wd, nd_q;
  logic               sk_re, sk_we;
  logic [SA-1:0]      sk_ra, sk_wa;
  hcb_pkg::stack_ent_t sk_wd, sk_q;

  logic [7:0]    li;
  logic          is_letter;
  logic [HA-1:0] cnt_idx;
  logic [CW-1:0] cnt_sel;
  logic          cnt_we;
  logic [CW-1:0] cnt_wd;
  logic [HA+1:0] lch, rch;
  logic          lv, rv;
  logic [HA+1:0] msel;
  logic [CW-1:0] mw;
  hcb_pkg::heap_ent_t chd;
  logic [CW:0]   sum_w;
  logic [CW-1:0] sum_sat;
  logic          out_free;

  assign li        = in_data.char_code - hcb_pkg::FirstLetter;
  assign is_letter = (in_data.char_code >= hcb_pkg::FirstLetter) &&
                     (li < 8'(hcb_pkg::Alpha));
  assign cnt_idx   = (cmd.op == hcb_pkg::OpCount) ? li[HA-1:0] : scan_r;
  assign cnt_sel   = cnt_r[cnt_idx];
  assign lch       = {1'b0, at_r, 1'b1};
  assign rch       = lch + (HA+2)'(1);
  assign lv        = lch < (HA+2)'(size_r);
  assign rv        = rch < (HA+2)'(size_r);
  assign sum_w     = {1'b0, a_r.w} + {1'b0, b_r.w};
  assign sum_sat   = sum_w[CW] ? CntMax : sum_w[CW-1:0];
  assign out_free  = !ov_r || !out_stall;

  always_comb begin
    msel = (HA+2)'(at_r);
    mw   = cur_r.w;
    chd  = cur_r;
    if (lv && (hpa_q.w < mw)) begin
      msel = lch;
      mw   = hpa_q.w;
      chd  = hpa_q;
    end
    if (rv && (hpb_q.w < mw)) begin
      msel = rch;
      chd  = hpb_q;
    end
  end

  always_comb begin
    scan_nxt = scan_r; leaves_nxt = leaves_r; size_nxt = size_r; ri_nxt = ri_r;
    at_nxt = at_r; m_nxt = m_r; next_nxt = next_r; sp_nxt = sp_r;
    cur_nxt = cur_r; top_nxt = top_r; a_nxt = a_r; b_nxt = b_r; e_nxt = e_r;
    ov_nxt = ov_r && out_stall;
    od_nxt = od_r;
    cnt_we = 1'b0; cnt_wd = cnt_sel;
    hp_rea = 1'b0; hp_reb = 1'b0; hp_we = 1'b0;
    hp_aa = '0; hp_ab = '0; hp_wa = '0; hp_wd = cur_r;
    nd_re = 1'b0; nd_we = 1'b0; nd_ra = e_r.n; nd_wa = next_r; nd_wd = '0;
    sk_re = 1'b0; sk_we = 1'b0; sk_ra = '0; sk_wa = sp_r; sk_wd = e_r;
    case (cmd.op)
      hcb_pkg::OpCount: begin
        scan_nxt   = '0;
        leaves_nxt = '0;
        if (cmd.acc && is_letter && (cnt_sel != CntMax)) begin
          cnt_we = 1'b1;
          cnt_wd = cnt_sel + CW'(1);
        end
      end
      hcb_pkg::OpScan: begin
        cnt_we   = 1'b1;
        cnt_wd   = '0;
        scan_nxt = (scan_r == LastIdx) ? '0 : scan_r + HA'(1);
        if (cnt_sel != '0) begin
          nd_we      = 1'b1;
          nd_wa      = NW'(leaves_r);
          nd_wd      = '{w: cnt_sel, l: '0, r: '0, sym: hcb_pkg::SymW'(scan_r)};
          hp_we      = 1'b1;
          hp_wa      = leaves_r[HA-1:0];
          hp_wd      = '{w: cnt_sel, n: NW'(leaves_r)};
          leaves_nxt = leaves_r + (HA+1)'(1);
        end
        size_nxt = leaves_nxt;
        next_nxt = NW'(leaves_nxt);
      end
      hcb_pkg::OpEmpty: begin
        ov_nxt = 1'b1;
        od_nxt = '{symbol: '0, code_length: '0, code_bits: '0, weight: '0,
                   empty_message: 1'b1, last_code: 1'b1};
      end
      hcb_pkg::OpRbInit: ri_nxt = size_r[HA:1];
      hcb_pkg::OpRbNext: begin
        at_nxt = ri_r - HA'(1);
        ri_nxt = ri_r - HA'(1);
      end
      hcb_pkg::OpSr0: begin
        hp_rea = 1'b1;
        hp_aa  = at_r;
      end
      hcb_pkg::OpSr1: begin
        cur_nxt = hpa_q;
        hp_rea  = 1'b1;
        hp_reb  = 1'b1;
        hp_aa   = lv ? lch[HA-1:0] : '0;
        hp_ab   = rv ? rch[HA-1:0] : '0;
      end
      hcb_pkg::OpScmp: begin
        m_nxt = msel[HA-1:0];
        if (msel != (HA+2)'(at_r)) begin
          hp_we = 1'b1;
          hp_wa = at_r;
          hp_wd = chd;
        end
      end
      hcb_pkg::OpSwr: begin
        hp_we  = 1'b1;
        hp_wa  = m_r;
        hp_wd  = cur_r;
        at_nxt = m_r;
      end
      hcb_pkg::OpP0: begin
        hp_rea = 1'b1;
        hp_reb = 1'b1;
        hp_aa  = '0;
        hp_ab  = HA'(size_r - (HA+1)'(1));
      end
      hcb_pkg::OpP1: begin
        top_nxt = hpa_q;
        hp_we   = 1'b1;
        hp_wa   = '0;
        hp_wd   = hpb_q;
      end
      hcb_pkg::OpP2: begin
        hp_we    = 1'b1;
        hp_wa    = HA'(size_r - (HA+1)'(1));
        hp_wd    = top_r;
        size_nxt = size_r - (HA+1)'(1);
        a_nxt    = b_r;
        b_nxt    = top_r;
      end
      hcb_pkg::OpPush: begin
        hp_we    = 1'b1;
        hp_wa    = size_r[HA-1:0];
        hp_wd    = '{w: sum_sat, n: next_r};
        nd_we    = 1'b1;
        nd_wa    = next_r;
        nd_wd    = '{w: sum_sat, l: a_r.n, r: b_r.n, sym: '0};
        size_nxt = size_r + (HA+1)'(1);
        next_nxt = next_r + NW'(1);
      end
      hcb_pkg::OpWr0: begin
        hp_rea = 1'b1;
        hp_aa  = '0;
      end
      hcb_pkg::OpWr1: begin
        sk_we  = 1'b1;
        sk_wa  = '0;
        sk_wd  = '{n: hpa_q.n, code: '0, len: '0};
        sp_nxt = SA'(1);
      end
      hcb_pkg::OpW0: begin
        sk_re  = 1'b1;
        sk_ra  = sp_r - SA'(1);
        sp_nxt = sp_r - SA'(1);
      end
      hcb_pkg::OpW1: begin
        e_nxt = sk_q;
        nd_re = 1'b1;
        nd_ra = sk_q.n;
      end
      hcb_pkg::OpEmit: begin
        ov_nxt = 1'b1;
        od_nxt = '{symbol: nd_q.sym, code_length: e_r.len, code_bits: e_r.code,
                   weight: nd_q.w, empty_message: 1'b0, last_code: (sp_r == '0)};
      end
      hcb_pkg::OpW2: begin
        sk_we = 1'b1;
        sk_wa = sp_r;
        sk_wd = '{n: nd_q.r, code: {e_r.code[hcb_pkg::CodeW-2:0], 1'b1},
                  len: e_r.len + hcb_pkg::LenW'(1)};
      end
      hcb_pkg::OpW3: begin
        sk_we  = 1'b1;
        sk_wa  = sp_r + SA'(1);
        sk_wd  = '{n: nd_q.l, code: {e_r.code[hcb_pkg::CodeW-2:0], 1'b0},
                   len: e_r.len + hcb_pkg::LenW'(1)};
        sp_nxt = sp_r + SA'(2);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < hcb_pkg::Alpha; i++) cnt_r[i] <= '0;
      ov_r     <= 1'b0;
      scan_r   <= '0;
      leaves_r <= '0;
      size_r   <= '0;
      sp_r     <= '0;
    end else begin
      if (cnt_we) cnt_r[cnt_idx] <= cnt_wd;
      ov_r     <= ov_nxt;
      scan_r   <= scan_nxt;
      leaves_r <= leaves_nxt;
      size_r   <= size_nxt;
      sp_r     <= sp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ri_r   <= ri_nxt;
    at_r   <= at_nxt;
    m_r    <= m_nxt;
    next_r <= next_nxt;
    cur_r  <= cur_nxt;
    top_r  <= top_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    e_r    <= e_nxt;
    od_r   <= od_nxt;
  end

  // heap, node and stack stores
  always_ff @(posedge clk) begin
    if (hp_we) hp[hp_wa] <= hp_wd;
    if (hp_rea) hpa_q <= hp[hp_aa];
    if (hp_reb) hpb_q <= hp[hp_ab];
  end

  always_ff @(posedge clk) begin
    if (nd_we) nd[nd_wa] <= nd_wd;
    if (nd_re) nd_q <= nd[nd_ra];
  end

  always_ff @(posedge clk) begin
    if (sk_we) sk[sk_wa] <= sk_wd;
    if (sk_re) sk_q <= sk[sk_ra];
  end

  assign st.scan_last   = (scan_r == LastIdx);
  assign st.leaves_zero = (leaves_r == '0);
  assign st.ri_zero     = (ri_r == '0);
  assign st.sift_stop   = (msel == (HA+2)'(at_r));
  assign st.size_one    = (size_r == (HA+1)'(1));
  assign st.sp_zero     = (sp_r == '0);
  assign st.is_leaf     = ({1'b0, e_r.n} < (NW+1)'(leaves_r));
  assign st.out_free    = out_free;

  assign out_valid = ov_r;
  assign out_data  = od_r;

  `HCB_ASSERT_IMP(a_size_bound, 1'b1, size_r <= (HA+1)'(hcb_pkg::Alpha))
  `HCB_ASSERT_IMP(a_sp_bound, 1'b1, sp_r <= SA'(hcb_pkg::StackDepth))
  `HCB_ASSERT_NXT(a_emit_valid, cmd.op == hcb_pkg::OpEmit, ov_r)

endmodule
`default_nettype wire

### sv/huffman_code_builder.sv
// channel  | handshake         | payload
// in       | in_valid/in_stall   | char_code, last_char
// out      | out_valid/out_stall | symbol, code_length, code_bits, weight,
//          |                     | empty_message, last_code
// one character per cycle while counting
// after the last character: a scan of the 26 letters, then heap
// rebuilds, a sift step per level, bound by the single heap write port
// code walk visits each tree node through the stack store
// rst_n is synchronous, active low; counts clear on reset
// input stalled in build/walk; walk holds while out_stall blocks a code
`default_nettype none
module huffman_code_builder (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire hcb_pkg::in_req_t  in_data,
  output logic                   in_stall,
  output logic                   out_valid,
  output hcb_pkg::out_req_t      out_data,
  input  wire logic              out_stall
);

  hcb_pkg::cmd_t  cmd;
  hcb_pkg::stat_t st;

  hcb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  hcb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .st        (st),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule
`default_nettype wire
